FILE: hw/rtl/kas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kas_pkg
// Shared widths, codes and types for the keyframe animation stepper.
// ----------------------------------------------------------------------------
package kas_pkg;

  localparam int FRAME_W   = 8;
  localparam int FRAME_B_W = 9;
  localparam int BLEND_W   = 16;
  localparam int SPEED_W   = 16;
  localparam int ELAPSED_W = 16;
  localparam int COUNT_W   = 9;
  localparam int PMODE_W   = 2;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam int MAX_FRAMES    = 256;
  localparam int FRAC_BITS_DEF = 16;

  // play modes
  localparam logic [PMODE_W-1:0] PM_STOP     = 2'd0;
  localparam logic [PMODE_W-1:0] PM_LOOP     = 2'd1;
  localparam logic [PMODE_W-1:0] PM_PINGPONG = 2'd2;
  localparam logic [PMODE_W-1:0] PM_ONCE     = 2'd3;

  // item kinds
  localparam logic ITEM_START = 1'b0;
  localparam logic ITEM_TICK  = 1'b1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_FIRST = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LAST  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PMODE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPEED = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COUNT = 3'd4;

  typedef struct packed {
    logic [FRAME_W-1:0]        first_frame;
    logic [FRAME_W-1:0]        last_frame;
    logic [PMODE_W-1:0]        play_mode;
    logic signed [SPEED_W-1:0] speed;
    logic [COUNT_W-1:0]        frame_count;
  } cfg_t;

  typedef struct packed {
    logic                      stop_only;
    logic                      empty;
    logic [FRAME_W-1:0]        lo;
    logic [FRAME_W-1:0]        hi;
    logic [FRAME_W-1:0]        seed;
    logic signed [SPEED_W-1:0] spd;
  } start_t;

endpackage

FILE: hw/rtl/kas_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kas_apb_regs
// APB register file holding the animation configuration.
// ----------------------------------------------------------------------------
module kas_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kas_pkg::ADDR_W-1:0] paddr,
  input  logic [kas_pkg::DATA_W-1:0] pwdata,
  output logic [kas_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output kas_pkg::cfg_t              cfg
);
  import kas_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_frame <= '0;
      cfg.last_frame  <= '0;
      cfg.play_mode   <= PM_STOP;
      cfg.speed       <= '0;
      cfg.frame_count <= COUNT_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_FIRST: cfg.first_frame <= pwdata[FRAME_W-1:0];
        REG_LAST:  cfg.last_frame  <= pwdata[FRAME_W-1:0];
        REG_PMODE: cfg.play_mode   <= pwdata[PMODE_W-1:0];
        REG_SPEED: cfg.speed       <= pwdata[SPEED_W-1:0];
        REG_COUNT: cfg.frame_count <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FIRST: prdata = DATA_W'(cfg.first_frame);
      REG_LAST:  prdata = DATA_W'(cfg.last_frame);
      REG_PMODE: prdata = DATA_W'(cfg.play_mode);
      REG_SPEED: prdata = DATA_W'($unsigned(cfg.speed));
      REG_COUNT: prdata = DATA_W'(cfg.frame_count);
      default:   prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/kas_start.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kas_start
// Start decode: clamps and orders the frame range, picks the seed frame.
// ----------------------------------------------------------------------------
module kas_start (
  input  kas_pkg::cfg_t   cfg,
  output kas_pkg::start_t st
);
  import kas_pkg::*;

  // frame_count never exceeds its register range
  localparam int MAX_C = (MAX_FRAMES > (1 << COUNT_W) - 1) ? (1 << COUNT_W) - 1 : MAX_FRAMES;

  logic [COUNT_W-1:0] lim;
  logic [FRAME_W-1:0] fc, lc;

  always_comb begin
    lim = cfg.frame_count;
    if (lim > COUNT_W'(MAX_C)) lim = COUNT_W'(MAX_C);
    if (lim == '0) lim = COUNT_W'(1);

    fc = ({1'b0, cfg.first_frame} >= lim) ? FRAME_W'(lim - COUNT_W'(1)) : cfg.first_frame;
    lc = ({1'b0, cfg.last_frame}  >= lim) ? FRAME_W'(lim - COUNT_W'(1)) : cfg.last_frame;

    st.stop_only = (cfg.speed == '0) && (cfg.play_mode == PM_STOP);
    st.empty     = (fc == lc);
    st.lo        = (lc < fc) ? lc : fc;
    st.hi        = (lc < fc) ? fc : lc;
    st.spd       = cfg.speed;
    // positive speed starts at the low end, zero or negative at the high end
    st.seed      = (cfg.speed > 0) ? st.lo : st.hi;
  end

endmodule

FILE: hw/rtl/kas_tick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kas_tick
// Tick datapath: step = speed * elapsed, saturate, wrap / reflect / clamp.
// ----------------------------------------------------------------------------
module kas_tick #(
  parameter int FRAC_BITS = kas_pkg::FRAC_BITS_DEF
) (
  input  logic [kas_pkg::FRAME_W+FRAC_BITS-1:0] position,
  input  logic signed [kas_pkg::SPEED_W-1:0]    velocity,
  input  logic [kas_pkg::PMODE_W-1:0]           active_mode,
  input  logic [kas_pkg::FRAME_W-1:0]           lo_frame,
  input  logic [kas_pkg::FRAME_W-1:0]           hi_frame,
  input  logic [kas_pkg::ELAPSED_W-1:0]         elapsed,
  output logic [kas_pkg::FRAME_W+FRAC_BITS-1:0] pos_next,
  output logic signed [kas_pkg::SPEED_W-1:0]    vel_next,
  output logic [kas_pkg::PMODE_W-1:0]           mode_next,
  output logic [kas_pkg::FRAME_W-1:0]           frame_a_next,
  output logic [kas_pkg::FRAME_B_W-1:0]         frame_b_next,
  output logic [kas_pkg::BLEND_W-1:0]           blend_next
);
  import kas_pkg::*;

  localparam int PW  = FRAME_W + FRAC_BITS;          // position width
  localparam int TW  = PW + 2;                        // signed trial position
  localparam int PRW = SPEED_W + ELAPSED_W + 1;       // signed product
  localparam int MGW = SPEED_W + ELAPSED_W;           // product magnitude
  localparam int UP  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int DN  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int MW  = MGW + UP;

  logic signed [PRW-1:0]     prod;
  logic                      neg;
  logic [MGW-1:0]            mag;
  logic [MW-1:0]             mag_sc;
  logic [PW-1:0]             lo_pos, hi_pos, span, step_mag;
  logic signed [TW-1:0]      pos_t, step_t, lo_t, hi_t, span_t, t, nt;
  logic signed [SPEED_W-1:0] vel_rev;
  logic [FRAME_B_W-1:0]      b_raw;
  logic [FRAC_BITS+BLEND_W-1:0] frac_x;

  always_comb begin
    prod   = PRW'(velocity) * PRW'($signed({1'b0, elapsed}));
    neg    = prod[PRW-1];
    mag    = neg ? MGW'(-prod) : MGW'(prod);
    mag_sc = (MW'(mag) << UP) >> DN;

    lo_pos = {lo_frame, {FRAC_BITS{1'b0}}};
    hi_pos = {hi_frame, {FRAC_BITS{1'b0}}};
    span   = hi_pos - lo_pos;
    // saturate to the span: one wrap or reflection is then enough
    step_mag = (mag_sc > MW'(span)) ? span : PW'(mag_sc);

    pos_t  = $signed({2'b00, position});
    step_t = $signed({2'b00, step_mag});
    lo_t   = $signed({2'b00, lo_pos});
    hi_t   = $signed({2'b00, hi_pos});
    span_t = $signed({2'b00, span});
    t      = neg ? pos_t - step_t : pos_t + step_t;

    vel_rev   = (velocity == {1'b1, {(SPEED_W-1){1'b0}}}) ?
                {1'b0, {(SPEED_W-1){1'b1}}} : -velocity;
    nt        = t;
    vel_next  = velocity;
    mode_next = active_mode;

    if (t < lo_t) begin
      case (active_mode)
        PM_LOOP:     nt = t + span_t;
        PM_PINGPONG: begin
          nt       = lo_t + lo_t - t;
          vel_next = vel_rev;
        end
        default: begin
          nt        = lo_t;
          mode_next = PM_STOP;
        end
      endcase
    end else if (t >= hi_t) begin
      case (active_mode)
        PM_LOOP:     nt = t - span_t;
        PM_PINGPONG: begin
          nt       = hi_t + hi_t - t;
          vel_next = vel_rev;
        end
        default: begin
          nt        = hi_t;
          mode_next = PM_STOP;
        end
      endcase
    end

    pos_next     = nt[PW-1:0];
    frame_a_next = pos_next[PW-1:FRAC_BITS];
    b_raw        = {1'b0, frame_a_next} + FRAME_B_W'(1);
    frame_b_next = (mode_next == PM_LOOP && b_raw == {1'b0, hi_frame}) ?
                   {1'b0, lo_frame} : b_raw;
    // top 16 fraction bits, zero padded below when the fraction is short
    frac_x       = {pos_next[FRAC_BITS-1:0], {BLEND_W{1'b0}}};
    blend_next   = frac_x[FRAC_BITS+BLEND_W-1 -: BLEND_W];
  end

endmodule

FILE: hw/rtl/keyframe_animation_stepper_core.sv
`timescale 1ns / 1ps
// Flow: an accepted item is held in the item register, then its result is
//   written to the state/result registers once the result stage is free.
// Throughput: one item per cycle unless stalled; the tick multiply, saturate
//   and wrap fit in the single stage between those two sets of registers.
// Reset (rst, synchronous): empties both stages, loads register defaults
//   (frame_count 1, all else 0) and clears position, range and mode to stopped.
// ----------------------------------------------------------------------------
// keyframe_animation_stepper_core
// Keyframe animation stepper: start items load a clamped frame range, tick
// items advance the playback position in loop, pingpong or once mode.
// ----------------------------------------------------------------------------
module keyframe_animation_stepper_core #(
  parameter int FRAC_BITS = kas_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [kas_pkg::ELAPSED_W-1:0] elapsed,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kas_pkg::FRAME_W-1:0]   frame_a,
  output logic [kas_pkg::FRAME_B_W-1:0] frame_b,
  output logic [kas_pkg::BLEND_W-1:0]   blend,
  output logic                          playing,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kas_pkg::ADDR_W-1:0]    paddr,
  input  logic [kas_pkg::DATA_W-1:0]    pwdata,
  output logic [kas_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import kas_pkg::*;

  localparam int PW = FRAME_W + FRAC_BITS;

  cfg_t   cfg;
  start_t st;

  // item register
  logic                 item_valid;
  logic                 item_mode;
  logic [ELAPSED_W-1:0] item_elapsed;

  // animation state; cur_* double as the result payload registers
  logic [PW-1:0]             position;
  logic signed [SPEED_W-1:0] velocity;
  logic [PMODE_W-1:0]        active_mode;
  logic [FRAME_W-1:0]        lo_frame, hi_frame;
  logic [FRAME_W-1:0]        cur_frame_a;
  logic [FRAME_B_W-1:0]      cur_frame_b;
  logic [BLEND_W-1:0]        cur_blend;

  // tick results
  logic [PW-1:0]             tk_pos;
  logic signed [SPEED_W-1:0] tk_vel;
  logic [PMODE_W-1:0]        tk_mode;
  logic [FRAME_W-1:0]        tk_a;
  logic [FRAME_B_W-1:0]      tk_b;
  logic [BLEND_W-1:0]        tk_blend;

  logic advance, step;

  kas_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kas_start u_start (
    .cfg (cfg),
    .st  (st)
  );

  kas_tick #(.FRAC_BITS(FRAC_BITS)) u_tick (
    .position     (position),
    .velocity     (velocity),
    .active_mode  (active_mode),
    .lo_frame     (lo_frame),
    .hi_frame     (hi_frame),
    .elapsed      (item_elapsed),
    .pos_next     (tk_pos),
    .vel_next     (tk_vel),
    .mode_next    (tk_mode),
    .frame_a_next (tk_a),
    .frame_b_next (tk_b),
    .blend_next   (tk_blend)
  );

  // The result stage is free when empty or being drained this cycle.
  // The item stage stalls only while a finished result is held.
  assign advance  = !out_valid || !out_stall;
  assign step     = item_valid && advance;
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      item_mode    <= ITEM_START;
      item_elapsed <= '0;
      out_valid    <= 1'b0;
      position     <= '0;
      velocity     <= '0;
      active_mode  <= PM_STOP;
      lo_frame     <= '0;
      hi_frame     <= '0;
      cur_frame_a  <= '0;
      cur_frame_b  <= '0;
      cur_blend    <= '0;
    end else begin
      if (!in_stall) begin
        item_valid <= in_valid;
        if (in_valid) begin
          item_mode    <= mode;
          item_elapsed <= elapsed;
        end
      end

      if (step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (step) begin
        if (item_mode == ITEM_START) begin
          if (st.stop_only) begin
            // stop request: range and reported frames kept
            active_mode <= PM_STOP;
          end else if (st.empty) begin
            // empty range: park on the single frame
            active_mode <= PM_STOP;
            cur_frame_a <= st.lo;
            cur_frame_b <= {1'b0, st.lo};
            cur_blend   <= '0;
          end else begin
            // reported frames stay until the first tick
            lo_frame    <= st.lo;
            hi_frame    <= st.hi;
            velocity    <= st.spd;
            position    <= {st.seed, {FRAC_BITS{1'b0}}};
            active_mode <= cfg.play_mode;
          end
        end else if (active_mode != PM_STOP) begin
          // a tick while stopped repeats the last result
          position    <= tk_pos;
          velocity    <= tk_vel;
          active_mode <= tk_mode;
          cur_frame_a <= tk_a;
          cur_frame_b <= tk_b;
          cur_blend   <= tk_blend;
        end
      end
    end
  end

  assign frame_a = cur_frame_a;
  assign frame_b = cur_frame_b;
  assign blend   = cur_blend;
  assign playing = (active_mode != PM_STOP);

endmodule

FILE: hw/rtl/kas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kas_checker
// Port-level checks on the stepper's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module kas_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [kas_pkg::FRAME_W-1:0]   frame_a,
  input logic [kas_pkg::FRAME_B_W-1:0] frame_b,
  input logic [kas_pkg::BLEND_W-1:0]   blend,
  input logic                          playing
);

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // input backs up only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // a fresh result comes from an accepted item that has passed the item register
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without an accepted item");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(frame_a) && $stable(frame_b) &&
       $stable(blend) && $stable(playing)))
    else $error("stalled result changed");

endmodule

bind keyframe_animation_stepper_core kas_checker u_kas_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .frame_a   (frame_a),
  .frame_b   (frame_b),
  .blend     (blend),
  .playing   (playing)
);
